// ===== hdl/gmp_pkg.sv =====
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared widths, register indexes and types for the grid max path block.
// ----------------------------------------------------------------------------
package gmp_pkg;

    localparam int GAIN_W       = 8;
    localparam int SUM_W        = 16;
    localparam int COUNT_W      = 6;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 4;
    localparam int GRID_LIMIT   = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(9);
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(9);

    // position of the cell being accepted, from the scan controller
    typedef struct packed {
        logic [COUNT_W-1:0] col;
        logic               row_first;
        logic               col_first;
        logic               last_col;
        logic               last_row;
    } pos_t;

endpackage

// ===== hdl/grid_max_path_with_blocks_top.sv =====
// ----------------------------------------------------------------------------
// grid_max_path_with_blocks_top
// Streaming best right/down path sum over a grid with blocked cells.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  s_      | s_valid / s_ready  | s_cell_gain[7:0], s_cell_blocked
//  m_      | m_valid / m_ready  | m_best_sum[15:0], m_reachable, m_frame_last
//  cfg_    | cfg_valid/cfg_ready| cfg_index[3:0], cfg_data[6:0]
//
// One cell per cycle sustained while m_ready does not hold the output register.
// The line store read is issued on the input beat and used in the compute
// stage, where the result is written back; a same-column write-back is
// forwarded (single-column frames). A stalled output holds the compute stage
// and the input side fills one more beat. Synchronous active-low reset clears
// control state; the line store needs no clearing.
// ----------------------------------------------------------------------------
module grid_max_path_with_blocks_top
    import gmp_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [GAIN_W-1:0]    s_cell_gain,
    input  logic                 s_cell_blocked,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SUM_W-1:0]     m_best_sum,
    output logic                 m_reachable,
    output logic                 m_frame_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EXT_W = (AW > COUNT_W) ? AW : COUNT_W;
    localparam int DW    = SUM_W + 1;

    pos_t               pos;
    logic               s_accept;
    logic               s1_adv;
    logic               out_free;
    logic [EXT_W-1:0]   col_ext;
    logic [AW-1:0]      rd_addr;
    logic               in_store;
    logic [DW-1:0]      rd_data;

    // compute stage
    logic               s1_valid_reg, s1_valid_next;
    logic [GAIN_W-1:0]  s1_gain_reg;
    logic               s1_blocked_reg;
    logic               s1_start_reg;
    logic               s1_row_first_reg;
    logic               s1_col_first_reg;
    logic               s1_frame_last_reg;
    logic               s1_in_store_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               fwd_reg, fwd_next;
    logic [DW-1:0]      fwd_data_reg;

    logic [SUM_W-1:0]   left_sum_reg;
    logic               left_ok_reg;

    logic [SUM_W-1:0]   up_sum;
    logic               up_ok;
    logic               have_left;
    logic               have_up;
    logic [SUM_W-1:0]   best;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   calc_sum;
    logic               calc_ok;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]   m_best_sum_reg;
    logic               m_reachable_reg;
    logic               m_frame_last_reg;

    gmp_scan_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (s_accept),
        .pos       (pos)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    assign col_ext  = EXT_W'(pos.col);
    assign rd_addr  = col_ext[AW-1:0];
    assign in_store = 32'(pos.col) < MAX_COLS;

    gmp_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (AW),
        .DW    (DW)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (s1_adv && s1_in_store_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({calc_ok, calc_sum}),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // cell recurrence
    always_comb begin
        up_sum    = fwd_reg ? fwd_data_reg[SUM_W-1:0] : rd_data[SUM_W-1:0];
        up_ok     = fwd_reg ? fwd_data_reg[SUM_W]     : rd_data[SUM_W];
        have_left = !s1_col_first_reg && left_ok_reg;
        have_up   = !s1_row_first_reg && s1_in_store_reg && up_ok;
        if (have_up && (!have_left || up_sum > left_sum_reg)) begin
            best = up_sum;
        end else begin
            best = left_sum_reg;
        end
        sum_wide = {1'b0, best} + (SUM_W + 1)'(s1_gain_reg);
        calc_sum = '0;
        calc_ok  = 1'b0;
        if (s1_start_reg) begin
            calc_ok = 1'b1;
        end else if (!s1_blocked_reg && (have_left || have_up)) begin
            calc_ok  = 1'b1;
            calc_sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        // write-back to the same column lands at the read edge: forward it
        fwd_next = fwd_reg;
        if (s_accept) begin
            fwd_next = s1_adv && s1_in_store_reg && (s1_addr_reg == rd_addr);
        end else if (s1_adv) begin
            fwd_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_sum_reg <= '0;
            left_ok_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fwd_reg      <= fwd_next;
            m_valid_reg  <= m_valid_next;
            if (s1_adv) begin
                left_sum_reg <= calc_sum;
                left_ok_reg  <= calc_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gain_reg       <= s_cell_gain;
            s1_blocked_reg    <= s_cell_blocked;
            s1_start_reg      <= pos.row_first && pos.col_first;
            s1_row_first_reg  <= pos.row_first;
            s1_col_first_reg  <= pos.col_first;
            s1_frame_last_reg <= pos.last_col && pos.last_row;
            s1_in_store_reg   <= in_store;
            s1_addr_reg       <= rd_addr;
            fwd_data_reg      <= {calc_ok, calc_sum};
        end
        if (s1_adv) begin
            m_best_sum_reg   <= calc_sum;
            m_reachable_reg  <= calc_ok;
            m_frame_last_reg <= s1_frame_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_sum   = m_best_sum_reg;
    assign m_reachable  = m_reachable_reg;
    assign m_frame_last = m_frame_last_reg;

    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reachable |-> m_best_sum == '0)
        else $error("unreachable cell carries a nonzero sum");

    a_beat_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted beat lost before compute stage");

    a_fwd_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarding flag set with empty compute stage");

endmodule

// ===== hdl/gmp_line_store.sv =====
// ----------------------------------------------------------------------------
// gmp_line_store
// Previous-row line store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gmp_line_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gmp_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmp_scan_ctrl
// Frame size registers and the raster row/column counters.
// ----------------------------------------------------------------------------
module gmp_scan_ctrl
    import gmp_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 advance,
    output pos_t                 pos
);

    logic [CFG_W-1:0]   rows_reg, rows_next;
    logic [CFG_W-1:0]   cols_reg, cols_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0]   rows_eff;
    logic [CFG_W-1:0]   cols_eff;
    logic               cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr) begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_next = cfg_data;
                REG_COLS_IN_USE: cols_next = cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes into 1..limit, and the columns also to MAX_COLS
    always_comb begin
        rows_eff = rows_reg;
        if (rows_reg == '0) begin
            rows_eff = CFG_W'(1);
        end else if (32'(rows_reg) > GRID_LIMIT) begin
            rows_eff = CFG_W'(GRID_LIMIT);
        end
        cols_eff = cols_reg;
        if (cols_reg == '0) begin
            cols_eff = CFG_W'(1);
        end else if (32'(cols_reg) > GRID_LIMIT) begin
            cols_eff = CFG_W'(GRID_LIMIT);
        end
        if (32'(cols_eff) > MAX_COLS) begin
            cols_eff = CFG_W'(MAX_COLS);
        end
    end

    always_comb begin
        pos.col       = col_reg;
        pos.row_first = (row_reg == '0);
        pos.col_first = (col_reg == '0);
        pos.last_col  = (CFG_W'(col_reg) + CFG_W'(1)) >= cols_eff;
        pos.last_row  = (CFG_W'(row_reg) + CFG_W'(1)) >= rows_eff;
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (advance) begin
            if (pos.last_col) begin
                col_next = '0;
                row_next = pos.last_row ? '0 : row_reg + COUNT_W'(1);
            end else begin
                col_next = col_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    a_col_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pos.last_col |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !pos.last_col |=> row_reg == $past(row_reg))
        else $error("row counter moved inside a row");

    a_counters_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(row_reg) && $stable(col_reg))
        else $error("counters moved without an accepted beat");

endmodule

// ===== tb/grid_max_path_with_blocks_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_max_path_with_blocks_top_tb
// Streams raster grids of gain/blocked cells into the block and compares
// every result beat against a cycle-free path-sum predictor kept in the bench,
// or against the typed result of a directed row. A short directed table covers
// the start cell, blocked cells, ties, cells with no way in and zero sizes.
// Random frames of many sizes follow, with idle cycles on both channels, a long
// output hold-off and register changes both at and inside frame boundaries.
// ----------------------------------------------------------------------------
module grid_max_path_with_blocks_top_tb;
    import gmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_CELLS = 1100;
    localparam int unsigned LINE_DEPTH   = MAX_COLS_DEF;

    // index that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

    typedef enum logic {STEP_CELL, STEP_CFG} step_kind_t;

    typedef struct packed {
        logic [SUM_W-1:0] best_sum;
        logic             reachable;
        logic             frame_last;
    } path_result_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [GAIN_W-1:0]    gain;
        logic                 blocked;
        logic                 typed;
        path_result_t         result;
    } plan_row_t;

    localparam int PLAN_LEN = 26;

    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // start cell right after reset, blocked flag and gain ignored
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd255, 1'b1, 1'b1, '{16'd0, 1'b1, 1'b0}},
        // shrink to 3x3 inside the frame
        '{STEP_CFG, REG_ROWS_IN_USE, 7'd3, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_COLS_IN_USE, 7'd3, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd255, 1'b0, 1'b1, '{16'd255, 1'b1, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd0, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd10, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd1, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd7, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd0, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd3, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd255, 1'b0, 1'b0, '0},
        // zero sizes count as one: single-cell frames
        '{STEP_CFG, REG_ROWS_IN_USE, 7'd0, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_COLS_IN_USE, 7'd0, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd200, 1'b1, 1'b1, '{16'd0, 1'b1, 1'b1}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd0, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b1}},
        // write to an index with no register behind it
        '{STEP_CFG, REG_SPARE, 7'd0, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_ROWS_IN_USE, 7'd2, 8'd0, 1'b0, 1'b0, '0},
        '{STEP_CFG, REG_COLS_IN_USE, 7'd2, 8'd0, 1'b0, 1'b0, '0},
        // 2x2 with equal sums from left and above
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd0, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd5, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd5, 1'b0, 1'b0, '0},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd1, 1'b0, 1'b0, '0},
        // 2x2 where the corner has no reachable neighbour
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd9, 1'b1, 1'b1, '{16'd0, 1'b1, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd4, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd4, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b0}},
        '{STEP_CELL, REG_ROWS_IN_USE, 7'd0, 8'd9, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b1}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [GAIN_W-1:0]    s_cell_gain;
    logic                 s_cell_blocked;
    logic                 m_valid;
    logic                 m_ready;
    logic [SUM_W-1:0]     m_best_sum;
    logic                 m_reachable;
    logic                 m_frame_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // bench copy of the block state
    logic [CFG_W-1:0]   grid_rows_cfg;
    logic [CFG_W-1:0]   grid_cols_cfg;
    logic [SUM_W-1:0]   line_sum [LINE_DEPTH];
    logic               line_ok  [LINE_DEPTH];
    logic [SUM_W-1:0]   left_sum;
    logic               left_ok;
    logic [COUNT_W-1:0] row_cnt;
    logic [COUNT_W-1:0] col_cnt;

    path_result_t expected_paths [$];

    int unsigned errors;
    int unsigned cycle_count;
    int unsigned results_seen;
    int unsigned frames_done;
    int unsigned unreachable_seen;
    int unsigned cells_sent;
    int unsigned blocked_sent;
    int unsigned random_sent;
    int unsigned settings_used;
    int unsigned phase_left;
    int unsigned hold_left;
    bit          hold_used;
    bit          steady;

    grid_max_path_with_blocks_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_gain    (s_cell_gain),
        .s_cell_blocked (s_cell_blocked),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_best_sum     (m_best_sum),
        .m_reachable    (m_reachable),
        .m_frame_last   (m_frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("grid_max_path_with_blocks_top: mismatch");
            $finish;
        end
    end

    // register value to grid size: zero means one, anything past the limit clamps
    function automatic int unsigned grid_span(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > GRID_LIMIT)
            return GRID_LIMIT;
        return v;
    endfunction

    // best right/down sum into the current cell, then move the scan position
    function automatic path_result_t advance_path(input logic [GAIN_W-1:0] gain,
                                                  input logic blocked);
        path_result_t res;
        int unsigned  best;
        bit           have;
        bit           last_col;
        bit           last_row;
        res      = '0;
        best     = 0;
        have     = 1'b0;
        last_col = (col_cnt + 1) >= grid_span(grid_cols_cfg);
        last_row = (row_cnt + 1) >= grid_span(grid_rows_cfg);
        if (row_cnt == 0 && col_cnt == 0) begin
            res.reachable = 1'b1;
        end else if (!blocked) begin
            if (col_cnt != 0 && left_ok) begin
                best = left_sum;
                have = 1'b1;
            end
            if (row_cnt != 0 && line_ok[col_cnt]) begin
                if (!have || line_sum[col_cnt] > best)
                    best = line_sum[col_cnt];
                have = 1'b1;
            end
            if (have) begin
                best += gain;
                res.best_sum  = (best > SUM_MAX) ? SUM_MAX : SUM_W'(best);
                res.reachable = 1'b1;
            end
        end
        line_sum[col_cnt] = res.best_sum;
        line_ok[col_cnt]  = res.reachable;
        left_sum          = res.best_sum;
        left_ok           = res.reachable;
        res.frame_last    = last_col && last_row;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return res;
    endfunction

    task automatic offer_cell(input logic [GAIN_W-1:0] gain, input logic blocked,
                              input logic typed, input path_result_t typed_res);
        path_result_t predicted;
        while (!steady && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cell_gain    <= gain;
        s_cell_blocked <= blocked;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = advance_path(gain, blocked);
        expected_paths.push_back(typed ? typed_res : predicted);
        cells_sent++;
        if (blocked)
            blocked_sent++;
    endtask

    task automatic offer_random_cell(input int unsigned blk_pct);
        logic [GAIN_W-1:0] gain;
        case ($urandom_range(7))
            0:       gain = '0;
            1:       gain = '1;
            default: gain = GAIN_W'($urandom);
        endcase
        steady = (random_sent >= 400 && random_sent < 650);
        offer_cell(gain, $urandom_range(99) < blk_pct, 1'b0, '0);
        random_sent++;
    endtask

    // only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_valid <= 1'b0;
        while (expected_paths.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_ROWS_IN_USE)
            grid_rows_cfg = val;
        else if (idx == REG_COLS_IN_USE)
            grid_cols_cfg = val;
    endtask

    always @(posedge aclk) begin : result_check
        path_result_t want;
        if (m_valid && m_ready) begin
            results_seen++;
            if (m_frame_last)
                frames_done++;
            if (!m_reachable)
                unreachable_seen++;
            if (expected_paths.size() == 0) begin
                $error("result beat with nothing expected: best_sum %0d", m_best_sum);
                errors++;
            end else begin
                want = expected_paths.pop_front();
                if (m_best_sum !== want.best_sum) begin
                    $error("best_sum: expected %0d, got %0d", want.best_sum, m_best_sum);
                    errors++;
                end
                if (m_reachable !== want.reachable) begin
                    $error("reachable: expected %0d, got %0d", want.reachable, m_reachable);
                    errors++;
                end
                if (m_frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last,
                           m_frame_last);
                    errors++;
                end
            end
        end
        // one long hold-off in the middle of a busy phase so the input backs up
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_used && results_seen >= 250 && phase_left >= 8) begin
            hold_used = 1'b1;
            hold_left = 90;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] new_rows;
        logic [CFG_W-1:0] new_cols;
        int unsigned      which;
        int unsigned      frame_cells;
        int unsigned      blk_pct;
        int unsigned      largest;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cell_gain    = '0;
        s_cell_blocked = 1'b0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        grid_rows_cfg  = ROWS_RESET;
        grid_cols_cfg  = COLS_RESET;
        left_sum       = '0;
        left_ok        = 1'b0;
        row_cnt        = '0;
        col_cnt        = '0;
        largest        = 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_sum[i] = '0;
            line_ok[i]  = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (DIRECTED_PLAN[i].kind == STEP_CFG)
                write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
            else
                offer_cell(DIRECTED_PLAN[i].gain, DIRECTED_PLAN[i].blocked,
                           DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].result);
        end

        while (random_sent < RANDOM_CELLS) begin
            case ($urandom_range(19))
                0: begin
                    new_rows = CFG_W'($urandom_range(64, 127));
                    new_cols = CFG_W'($urandom_range(1, 2));
                end
                1: begin
                    new_rows = CFG_W'($urandom_range(1, 2));
                    new_cols = CFG_W'($urandom_range(64, 127));
                end
                2, 3: begin
                    new_rows = CFG_W'($urandom_range(0, 1));
                    new_cols = CFG_W'($urandom_range(0, 8));
                end
                default: begin
                    new_rows = CFG_W'($urandom_range(1, 8));
                    new_cols = CFG_W'($urandom_range(1, 8));
                end
            endcase
            which = $urandom_range(3);
            // a wider line would read entries the current frame never wrote
            if (which != 1 && grid_span(new_cols) > grid_span(grid_cols_cfg)) begin
                while (row_cnt != 0 || col_cnt != 0)
                    offer_random_cell(20);
            end
            if (which != 2)
                write_reg(REG_ROWS_IN_USE, new_rows);
            if (which != 1)
                write_reg(REG_COLS_IN_USE, new_cols);
            settings_used++;

            frame_cells = grid_span(grid_rows_cfg) * grid_span(grid_cols_cfg);
            if (frame_cells > largest)
                largest = frame_cells;
            phase_left = frame_cells * ((frame_cells > 32) ? 1 : $urandom_range(1, 3));
            if (frame_cells > 1 && $urandom_range(2) == 0)
                phase_left += $urandom_range(1, frame_cells - 1);
            case ($urandom_range(3))
                0:       blk_pct = 0;
                1:       blk_pct = 12;
                2:       blk_pct = 30;
                default: blk_pct = 70;
            endcase
            while (phase_left != 0) begin
                offer_random_cell(blk_pct);
                phase_left--;
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (expected_paths.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d cells sent (%0d blocked) under %0d random size settings, largest %0d",
                 cells_sent, blocked_sent, settings_used, largest);
        $display("%0d results checked, %0d unreachable, %0d frames closed",
                 results_seen, unreachable_seen, frames_done);
        if (errors == 0)
            $display("grid_max_path_with_blocks_top: match");
        else
            $display("grid_max_path_with_blocks_top: mismatch");
        $finish;
    end

endmodule
